// ----- design/coab_pkg.sv -----
package coab_pkg;

    localparam int unsigned DimMax      = 8192;
    localparam int unsigned NumLayouts  = 6;

    // register index = paddr[4:2]
    typedef enum logic [2:0] {
        REG_PIXEL_LAYOUT = 3'd0,
        REG_AREA_X       = 3'd1,
        REG_AREA_Y       = 3'd2,
        REG_CURSOR_X     = 3'd3,
        REG_CURSOR_Y     = 3'd4,
        REG_FRAME_WIDTH  = 3'd5,
        REG_FRAME_HEIGHT = 3'd6,
        REG_UNUSED       = 3'd7
    } coab_reg_idx_t;

    typedef struct packed {
        logic        [2:0]  pixel_layout;
        logic        [12:0] area_x;
        logic        [12:0] area_y;
        logic signed [13:0] cursor_x;
        logic signed [13:0] cursor_y;
        logic        [13:0] frame_width;
        logic        [13:0] frame_height;
    } coab_cfg_t;

    // byte index of each colour channel within the frame word
    function automatic logic [1:0] r_byte(input logic [2:0] layout);
        logic [1:0] idx;
        case (layout)
            3'd0:    idx = 2'd2;
            3'd1:    idx = 2'd0;
            3'd2:    idx = 2'd2;
            3'd3:    idx = 2'd0;
            3'd4:    idx = 2'd3;
            3'd5:    idx = 2'd1;
            default: idx = 2'd0;
        endcase
        return idx;
    endfunction

    function automatic logic [1:0] g_byte(input logic [2:0] layout);
        logic [1:0] idx;
        case (layout)
            3'd4, 3'd5: idx = 2'd2;
            default:    idx = 2'd1;
        endcase
        return idx;
    endfunction

    function automatic logic [1:0] b_byte(input logic [2:0] layout);
        logic [1:0] idx;
        case (layout)
            3'd0:    idx = 2'd0;
            3'd1:    idx = 2'd2;
            3'd2:    idx = 2'd0;
            3'd3:    idx = 2'd2;
            3'd4:    idx = 2'd1;
            3'd5:    idx = 2'd3;
            default: idx = 2'd0;
        endcase
        return idx;
    endfunction

endpackage

// ----- design/coab_cfg_regs.sv -----
module coab_cfg_regs
    import coab_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output coab_cfg_t   cfg
);

    coab_cfg_t     cfg_reg;
    coab_reg_idx_t idx;
    logic          wr_en;

    assign idx    = coab_reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            case (idx)
                REG_PIXEL_LAYOUT: cfg_reg.pixel_layout <= pwdata[2:0];
                REG_AREA_X:       cfg_reg.area_x       <= pwdata[12:0];
                REG_AREA_Y:       cfg_reg.area_y       <= pwdata[12:0];
                REG_CURSOR_X:     cfg_reg.cursor_x     <= signed'(pwdata[13:0]);
                REG_CURSOR_Y:     cfg_reg.cursor_y     <= signed'(pwdata[13:0]);
                REG_FRAME_WIDTH:  cfg_reg.frame_width  <= pwdata[13:0];
                REG_FRAME_HEIGHT: cfg_reg.frame_height <= pwdata[13:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_PIXEL_LAYOUT: prdata = {29'd0, cfg_reg.pixel_layout};
            REG_AREA_X:       prdata = {19'd0, cfg_reg.area_x};
            REG_AREA_Y:       prdata = {19'd0, cfg_reg.area_y};
            REG_CURSOR_X:     prdata = {{18{cfg_reg.cursor_x[13]}}, cfg_reg.cursor_x};
            REG_CURSOR_Y:     prdata = {{18{cfg_reg.cursor_y[13]}}, cfg_reg.cursor_y};
            REG_FRAME_WIDTH:  prdata = {18'd0, cfg_reg.frame_width};
            REG_FRAME_HEIGHT: prdata = {18'd0, cfg_reg.frame_height};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

// ----- design/coab_blend_core.sv -----
module coab_blend_core
    import coab_pkg::*;
(
    input  coab_cfg_t   cfg,
    input  logic [7:0]  cursor_col,
    input  logic [7:0]  cursor_line,
    input  logic [31:0] cursor_argb,
    input  logic [31:0] frame_pixel,
    output logic [31:0] pixel_out,
    output logic [12:0] target_x,
    output logic [12:0] target_y,
    output logic        covered
);

    localparam logic [13:0] DimCap = 14'(DimMax);

    logic signed [15:0] tx;
    logic signed [15:0] ty;
    logic        [13:0] fw;
    logic        [13:0] fh;
    logic               layout_ok;
    logic               hit;
    logic        [7:0]  alpha;
    logic        [7:0]  inv_alpha;
    logic        [1:0]  ri;
    logic        [1:0]  gi;
    logic        [1:0]  bi;

    // clamp oversized frame dims
    assign fw = (cfg.frame_width  > DimCap) ? DimCap : cfg.frame_width;
    assign fh = (cfg.frame_height > DimCap) ? DimCap : cfg.frame_height;

    assign tx = 16'(cfg.cursor_x) - signed'({3'd0, cfg.area_x})
              + signed'({8'd0, cursor_col});
    assign ty = 16'(cfg.cursor_y) - signed'({3'd0, cfg.area_y})
              + signed'({8'd0, cursor_line});

    assign layout_ok = (cfg.pixel_layout < 3'(NumLayouts));
    assign hit = layout_ok
               && !tx[15] && (tx < signed'({2'd0, fw}))
               && !ty[15] && (ty < signed'({2'd0, fh}));

    assign alpha     = cursor_argb[31:24];
    assign inv_alpha = 8'd255 - alpha;
    assign ri        = r_byte(cfg.pixel_layout);
    assign gi        = g_byte(cfg.pixel_layout);
    assign bi        = b_byte(cfg.pixel_layout);

    // per byte: find the channel mapped onto it, then blend
    always_comb begin
        logic [7:0]  d;
        logic [7:0]  src;
        logic        sel;
        logic [15:0] prod;
        logic [16:0] sum;
        logic [8:0]  quot;
        for (int k = 0; k < 4; k++) begin
            d    = frame_pixel[8*k +: 8];
            sel  = 1'b1;
            src  = 8'd0;
            if (ri == 2'(k)) begin
                src = cursor_argb[23:16];
            end else if (gi == 2'(k)) begin
                src = cursor_argb[15:8];
            end else if (bi == 2'(k)) begin
                src = cursor_argb[7:0];
            end else begin
                sel = 1'b0;
            end
            prod = d * inv_alpha;
            // x/255 for x < 65535 as (x + (x>>8) + 1) >> 8, x = prod + 127
            sum  = 17'(prod) + 17'd127;
            sum  = sum + 17'(sum[16:8]) + 17'd1;
            quot = sum[16:8];
            if (hit && sel) begin
                if (alpha == 8'd255) begin
                    pixel_out[8*k +: 8] = src;
                end else begin
                    pixel_out[8*k +: 8] = quot[7:0] + src;
                end
            end else begin
                pixel_out[8*k +: 8] = d;
            end
        end
    end

    assign target_x = hit ? tx[12:0] : 13'd0;
    assign target_y = hit ? ty[12:0] : 13'd0;
    assign covered  = hit;

endmodule

// ----- design/cursor_overlay_alpha_blend_top.sv -----
// Channel   | Ports                                                  | Dir | Beat
// ----------+--------------------------------------------------------+-----+------------------
// input     | s_valid/s_ready, s_cursor_col/line/argb, s_frame_pixel | in  | one cursor pixel
// result    | m_valid/m_ready, m_pixel_out, m_target_x/y, m_covered  | out | one blended pixel
// config    | psel/penable/pwrite/paddr/pwdata/prdata/pready         | io  | one register write
//
// Two register stages: input register, blend logic, result register.
// One beat per cycle sustained while m_ready stays high; a taken beat sits in the input
// register, then loads the result register once it is free, and m_valid rises with it.
// The input stage takes a beat whenever it is empty or moving on, so a held
// result does not stop intake until both stages are full.
// Reset (aresetn, synchronous, active low) empties both stages and zeroes
// the configuration registers.
module cursor_overlay_alpha_blend_top
    import coab_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // input beats
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_cursor_col,
    input  logic [7:0]  s_cursor_line,
    input  logic [31:0] s_cursor_argb,
    input  logic [31:0] s_frame_pixel,

    // result beats
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_pixel_out,
    output logic [12:0] m_target_x,
    output logic [12:0] m_target_y,
    output logic        m_covered
);

    coab_cfg_t cfg;

    // input stage
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  col_reg;
    logic [7:0]  row_reg;
    logic [31:0] argb_reg;
    logic [31:0] pix_reg;

    // result stage
    logic        out_valid_reg, out_valid_next;
    logic [31:0] pixel_out_reg;
    logic [12:0] target_x_reg;
    logic [12:0] target_y_reg;
    logic        covered_reg;

    // blend logic outputs
    logic [31:0] pixel_out_c;
    logic [12:0] target_x_c;
    logic [12:0] target_y_c;
    logic        covered_c;

    logic out_ready;
    logic in_take;
    logic out_load;

    coab_cfg_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    coab_blend_core u_core (
        .cfg         (cfg),
        .cursor_col  (col_reg),
        .cursor_line (row_reg),
        .cursor_argb (argb_reg),
        .frame_pixel (pix_reg),
        .pixel_out   (pixel_out_c),
        .target_x    (target_x_c),
        .target_y    (target_y_c),
        .covered     (covered_c)
    );

    // result stage frees up when empty or being drained
    assign out_ready = !out_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || out_ready;
    assign in_take   = s_valid && s_ready;
    assign out_load  = in_valid_reg && out_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (out_load) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (in_take) begin
            col_reg  <= s_cursor_col;
            row_reg  <= s_cursor_line;
            argb_reg <= s_cursor_argb;
            pix_reg  <= s_frame_pixel;
        end
        if (out_load) begin
            pixel_out_reg <= pixel_out_c;
            target_x_reg  <= target_x_c;
            target_y_reg  <= target_y_c;
            covered_reg   <= covered_c;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_pixel_out = pixel_out_reg;
    assign m_target_x  = target_x_reg;
    assign m_target_y  = target_y_reg;
    assign m_covered   = covered_reg;

endmodule

// ----- verif/cursor_overlay_alpha_blend_top_tb.sv -----
`timescale 1ns / 100ps

module cursor_overlay_alpha_blend_top_tb
    import coab_pkg::*;
();

    // layout codes as held in the pixel_layout register
    localparam logic [2:0] LAY_24_RGB  = 3'd0;
    localparam logic [2:0] LAY_24_BGR  = 3'd1;
    localparam logic [2:0] LAY_32_XRGB = 3'd2;
    localparam logic [2:0] LAY_32_XBGR = 3'd3;
    localparam logic [2:0] LAY_32_RGBX = 3'd4;
    localparam logic [2:0] LAY_32_BGRX = 3'd5;
    localparam logic [2:0] LAY_NONE    = 3'd6;
    localparam logic [2:0] LAY_NONE_HI = 3'd7;

    localparam int unsigned HoldCycles  = 64;   // long receiver hold-off
    localparam int unsigned RandPhases  = 10;
    localparam int unsigned PhaseBeats  = 40;

    typedef struct packed {
        logic [31:0] pixel;
        logic [12:0] tx;
        logic [12:0] ty;
        logic        cov;
    } blended_t;

    // Scoreboard: holds a copy of the registers and the queue of blended pixels
    // still owed by the block.
    class blend_scoreboard;
        coab_cfg_t   cfg;
        blended_t    blended_q[$];
        int unsigned faults;
        int unsigned red_at[6]   = '{2, 0, 2, 0, 3, 1};
        int unsigned green_at[6] = '{1, 1, 1, 1, 2, 2};
        int unsigned blue_at[6]  = '{0, 2, 0, 2, 1, 3};

        function new();
            cfg    = '0;
            faults = 0;
        endfunction

        function void set_reg(coab_reg_idx_t idx, logic [31:0] v);
            case (idx)
                REG_PIXEL_LAYOUT: cfg.pixel_layout = v[2:0];
                REG_AREA_X:       cfg.area_x       = v[12:0];
                REG_AREA_Y:       cfg.area_y       = v[12:0];
                REG_CURSOR_X:     cfg.cursor_x     = v[13:0];
                REG_CURSOR_Y:     cfg.cursor_y     = v[13:0];
                REG_FRAME_WIDTH:  cfg.frame_width  = v[13:0];
                REG_FRAME_HEIGHT: cfg.frame_height = v[13:0];
                default: ;
            endcase
        endfunction

        // premultiplied over on one byte of the frame word
        function logic [31:0] over_byte(logic [31:0] word, int unsigned at,
                                        logic [7:0] src, logic [7:0] a);
            int unsigned d;
            int unsigned v;
            d = (word >> (8 * at)) & 32'hFF;
            if (a == 8'hFF)
                v = 32'(src);
            else
                v = ((d * (255 - a) + 127) / 255 + src) & 32'hFF;
            word[8*at +: 8] = v[7:0];
            return word;
        endfunction

        function blended_t blend_over(logic [7:0] col, logic [7:0] row,
                                      logic [31:0] argb, logic [31:0] pix);
            blended_t r;
            int       fw;
            int       fh;
            int       tx;
            int       ty;
            int       cx;
            int       cy;
            fw = (cfg.frame_width > DimMax) ? int'(DimMax) : int'(cfg.frame_width);
            fh = (cfg.frame_height > DimMax) ? int'(DimMax) : int'(cfg.frame_height);
            cx = $signed(cfg.cursor_x);
            cy = $signed(cfg.cursor_y);
            tx = cx - int'(cfg.area_x) + int'(col);
            ty = cy - int'(cfg.area_y) + int'(row);
            r  = '0;
            if (cfg.pixel_layout < NumLayouts && tx >= 0 && tx < fw && ty >= 0 && ty < fh) begin
                pix   = over_byte(pix, red_at[cfg.pixel_layout],   argb[23:16], argb[31:24]);
                pix   = over_byte(pix, green_at[cfg.pixel_layout], argb[15:8],  argb[31:24]);
                pix   = over_byte(pix, blue_at[cfg.pixel_layout],  argb[7:0],   argb[31:24]);
                r.tx  = tx[12:0];
                r.ty  = ty[12:0];
                r.cov = 1'b1;
            end
            r.pixel = pix;
            return r;
        endfunction

        function void note_cursor_beat(logic [7:0] col, logic [7:0] row,
                                       logic [31:0] argb, logic [31:0] pix);
            blended_q.push_back(blend_over(col, row, argb, pix));
        endfunction

        function void flag(string msg);
            faults++;
            if (faults <= 10)
                $display("%0t: %s", $time, msg);
        endfunction

        function void check_blended_beat(blended_t got);
            blended_t want;
            if (blended_q.size() == 0) begin
                flag($sformatf("result beat with nothing owed: pix=%h x=%0d y=%0d cov=%b",
                               got.pixel, got.tx, got.ty, got.cov));
                return;
            end
            want = blended_q.pop_front();
            if (got.pixel !== want.pixel || got.tx !== want.tx ||
                got.ty !== want.ty || got.cov !== want.cov)
                flag($sformatf("mismatch: want pix=%h x=%0d y=%0d cov=%b, got pix=%h x=%0d y=%0d cov=%b",
                               want.pixel, want.tx, want.ty, want.cov,
                               got.pixel, got.tx, got.ty, got.cov));
        endfunction
    endclass

    // --------------------------------------------------------------------
    // DUT signals; everything the testbench drives starts at a known value
    // --------------------------------------------------------------------
    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [4:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [7:0]  s_cursor_col  = '0;
    logic [7:0]  s_cursor_line = '0;
    logic [31:0] s_cursor_argb = '0;
    logic [31:0] s_frame_pixel = '0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [31:0] m_pixel_out;
    logic [12:0] m_target_x;
    logic [12:0] m_target_y;
    logic        m_covered;

    // idling controls, flipped by the stimulus between phases
    bit tx_gaps  = 1'b1;
    bit rx_gaps  = 1'b1;
    bit hold_req = 1'b0;

    blend_scoreboard sb = new();

    cursor_overlay_alpha_blend_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cursor_col  (s_cursor_col),
        .s_cursor_line (s_cursor_line),
        .s_cursor_argb (s_cursor_argb),
        .s_frame_pixel (s_frame_pixel),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_out   (m_pixel_out),
        .m_target_x    (m_target_x),
        .m_target_y    (m_target_y),
        .m_covered     (m_covered)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Both handshakes sampled on the edge itself: values seen here are the
    // ones the block sees, since all drives are nonblocking.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_cursor_beat(s_cursor_col, s_cursor_line, s_cursor_argb, s_frame_pixel);
            if (m_valid && m_ready)
                sb.check_blended_beat('{m_pixel_out, m_target_x, m_target_y, m_covered});
        end
    end

    // Result sink. Random back-pressure, or a long hold-off counted here so
    // the block fills both stages and drops s_ready.
    initial begin : result_sink
        int unsigned held;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                for (held = 1; held < HoldCycles; held++)
                    @(posedge aclk);
            end else begin
                m_ready <= !(rx_gaps && $urandom_range(99) < 30);
            end
        end
    end

    // APB write with a setup phase and an access phase; psel is then dropped before the task
    // returns, so it is never lowered and raised in the same step.
    task automatic apb_write(input coab_reg_idx_t idx, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(idx, v);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_config(input logic [2:0] lay, input int ax, input int ay,
                               input int cx, input int cy, input int fw, input int fh);
        apb_write(REG_PIXEL_LAYOUT, 32'(lay));
        apb_write(REG_AREA_X,       32'(ax) & 32'h1FFF);
        apb_write(REG_AREA_Y,       32'(ay) & 32'h1FFF);
        apb_write(REG_CURSOR_X,     32'(cx) & 32'h3FFF);
        apb_write(REG_CURSOR_Y,     32'(cy) & 32'h3FFF);
        apb_write(REG_FRAME_WIDTH,  32'(fw) & 32'h3FFF);
        apb_write(REG_FRAME_HEIGHT, 32'(fh) & 32'h3FFF);
    endtask

    // Offer one beat; valid stays up until taken. Returns on the accepting edge.
    task automatic send_pixel(input logic [7:0] col, input logic [7:0] row,
                              input logic [31:0] argb, input logic [31:0] pix);
        while (tx_gaps && $urandom_range(99) < 30) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_cursor_col  <= col;
        s_cursor_line <= row;
        s_cursor_argb <= argb;
        s_frame_pixel <= pix;
        do @(posedge aclk); while (!s_ready);
    endtask

    // alpha pulled towards the two ends, where the blend changes shape
    function automatic logic [31:0] pick_argb();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(3))
            0:       v[31:24] = 8'h00;
            1:       v[31:24] = 8'hFF;
            default: ;
        endcase
        return v;
    endfunction

    task automatic random_beats(input int unsigned n);
        int unsigned k;
        for (k = 0; k < n; k++)
            send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)), pick_argb(),
                       $urandom());
    endtask

    // Sender pauses until every owed result has come back, plus pipeline slack.
    task automatic wait_blended_empty();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.blended_q.size() != 0);
        repeat (3) @(posedge aclk);
    endtask

    function automatic int pick_dim();
        case ($urandom_range(4))
            0:       return $urandom_range(64, 1);
            1:       return $urandom_range(8191, 65);
            2:       return int'(DimMax);
            3:       return $urandom_range(16383, 8193);
            default: return $urandom_range(300);
        endcase
    endfunction

    // cursor origin placed so the 256-wide image straddles or sits near the
    // frame, either at the near edge or the far one
    function automatic int aim(input int origin, input int dim);
        int off;
        int lim;
        lim = (dim > int'(DimMax)) ? int'(DimMax) : dim;
        if ($urandom_range(1))
            off = int'($urandom_range(400)) - 200;
        else
            off = lim - int'($urandom_range(300));
        off += origin;
        if (off > 8191)
            off = 8191;
        if (off < -8192)
            off = -8192;
        return off;
    endfunction

    task automatic random_config();
        int         fw;
        int         fh;
        int         ax;
        int         ay;
        logic [2:0] lay;
        fw  = pick_dim();
        fh  = pick_dim();
        ax  = $urandom_range(1) ? 0 : int'($urandom_range(8191));
        ay  = $urandom_range(1) ? 0 : int'($urandom_range(8191));
        if ($urandom_range(7) == 0)
            lay = $urandom_range(1) ? LAY_NONE : LAY_NONE_HI;
        else
            lay = 3'($urandom_range(5));
        load_config(lay, ax, ay, aim(ax, fw), aim(ay, fh), fw, fh);
    endtask

    // --------------------------------------------------------------------
    // Stimulus
    // --------------------------------------------------------------------
    initial begin : stimulus
        int unsigned ph;
        int unsigned lay;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset config has a zero-sized frame: everything passes through
        random_beats(3);
        wait_blended_empty();

        // small 16x16 frame at the origin, 32-bit layout with a spare byte
        load_config(LAY_32_XRGB, 0, 0, 0, 0, 16, 16);
        send_pixel(8'd0,   8'd0,   32'hFF12_3456, 32'h89AB_CDEF); // opaque replace
        send_pixel(8'd15,  8'd15,  32'h00FF_FFFF, 32'hFFFF_FFFF); // additive wrap
        send_pixel(8'd16,  8'd0,   32'hFF00_0000, 32'h1234_5678); // just right of frame
        send_pixel(8'd0,   8'd16,  32'hFF00_0000, 32'h1234_5678); // just below frame
        send_pixel(8'd255, 8'd255, 32'h8080_8080, 32'h7F7F_7F7F);
        send_pixel(8'd3,   8'd7,   32'h0100_0000, 32'hFFFF_FFFF); // near-transparent
        send_pixel(8'd7,   8'd3,   32'hFE01_0203, 32'hFFFF_FFFF); // near-opaque
        send_pixel(8'd1,   8'd1,   32'h0000_0000, 32'h0000_0000);
        send_pixel(8'd9,   8'd9,   32'h8080_8080, 32'h7F7F_7F7F); // rounding mid-point
        wait_blended_empty();

        // every layout code, including the unsupported ones
        for (lay = 0; lay < 8; lay++) begin
            load_config(3'(lay), 0, 0, 0, 0, 16, 16);
            send_pixel(8'($urandom_range(15)), 8'($urandom_range(15)), 32'hFF5A_A5C3,
                       $urandom());
            send_pixel(8'($urandom_range(15)), 8'($urandom_range(15)), pick_argb(),
                       $urandom());
            wait_blended_empty();
        end

        // origin extremes: area and cursor registers at their top values, first target lands at 0
        load_config(LAY_24_RGB, 8191, 8191, 8191, 8191, 8192, 8192);
        send_pixel(8'd0,   8'd0,   pick_argb(), $urandom());
        send_pixel(8'd255, 8'd255, pick_argb(), $urandom());
        wait_blended_empty();
        // most negative target: never covered
        load_config(LAY_32_BGRX, 8191, 8191, -8192, -8192, 8192, 8192);
        send_pixel(8'd255, 8'd255, pick_argb(), $urandom());
        wait_blended_empty();
        // oversized frame clamps to 8192: column 8191 hits, 8192 misses
        load_config(LAY_24_BGR, 0, 0, 8191, 8191, 16383, 16383);
        send_pixel(8'd0, 8'd0, 32'hFFAB_CDEF, $urandom());
        send_pixel(8'd1, 8'd0, 32'hFFAB_CDEF, $urandom());
        wait_blended_empty();
        // zero width with tall frame: nothing covered; 1x1 frame: one hit
        load_config(LAY_32_RGBX, 0, 0, 0, 0, 0, 8192);
        send_pixel(8'd0, 8'd0, pick_argb(), $urandom());
        wait_blended_empty();
        load_config(LAY_32_XBGR, 0, 0, 0, 0, 1, 1);
        send_pixel(8'd0, 8'd0, pick_argb(), $urandom());
        send_pixel(8'd1, 8'd0, pick_argb(), $urandom());
        wait_blended_empty();

        // random phases; one runs flat out, one stalls the sink for a long
        // stretch while the source keeps offering
        for (ph = 0; ph < RandPhases; ph++) begin
            random_config();
            tx_gaps = (ph != 3 && ph != 6);
            rx_gaps = (ph != 3);
            if (ph == 6)
                hold_req = 1'b1;
            random_beats(PhaseBeats);
            wait_blended_empty();
        end
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;

        repeat (4) @(posedge aclk);
        if (sb.faults == 0 && sb.blended_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
design/coab_pkg.sv
design/coab_cfg_regs.sv
design/coab_blend_core.sv
design/cursor_overlay_alpha_blend_top.sv
verif/cursor_overlay_alpha_blend_top_tb.sv
